// File: rtl/slbs_pkg.sv
// shared types and constants for the status led and beep sequencer
// no dependencies
`default_nettype none

package slbs_pkg;

    localparam int unsigned PHASE_STEPS = 20;
    localparam int unsigned CMDQ_DEPTH  = 4;

    localparam logic [15:0] DEFAULT_FREQ  = 16'd2000;
    localparam logic [15:0] DEFAULT_MS    = 16'd80;
    localparam logic [7:0]  DEFAULT_COUNT = 8'd1;
    localparam logic [11:0] TONE_TICK_MAX = 12'd4095;
    localparam logic [1:0]  GAP_TICKS     = 2'd2;

    // led pattern register codes
    localparam logic [2:0] PAT_OFF          = 3'd0;
    localparam logic [2:0] PAT_BOOT_AMBER   = 3'd1;
    localparam logic [2:0] PAT_OK_BREATHE   = 3'd2;
    localparam logic [2:0] PAT_CONFIG_BLINK = 3'd3;
    localparam logic [2:0] PAT_UPDATE_RAMP  = 3'd4;
    localparam logic [2:0] PAT_FAULT_BLINK  = 3'd5;

    localparam logic [6:0] AMBER_RED     = 7'd60;
    localparam logic [5:0] AMBER_GREEN   = 6'd30;
    localparam logic [5:0] BREATHE_BASE  = 6'd8;
    localparam logic [5:0] BREATHE_STEP  = 6'd5;
    localparam logic [6:0] CONFIG_BLUE   = 7'd80;
    localparam logic [6:0] FAULT_RED     = 7'd100;
    localparam logic [3:0] BLINK_ON_STEPS = 4'd5;

    // one beep request after defaults, tone length already in ticks
    typedef struct packed {
        logic [15:0] freq;
        logic [11:0] ticks;
        logic [7:0]  count;
    } t_beep;

    // classified item handed from front to back
    typedef struct packed {
        logic  is_req;
        t_beep beep;
    } t_cmd;

    typedef struct packed {
        logic buzzer;
        logic tone_on;
        logic gap_on;
        logic fifo_over;
    } t_seq_status;

endpackage

`default_nettype wire

// File: rtl/slbs_front.sv
// front part: takes items, applies request defaults, converts tone length to ticks
// depends on slbs_pkg
`default_nettype none

module slbs_front #(
    parameter int unsigned TICK_MS = 50
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_is_req,
    input  wire  [15:0]       i_freq,
    input  wire  [15:0]       i_ms,
    input  wire  [7:0]        i_count,
    output logic              o_cmd_valid,
    input  wire               i_cmd_ready,
    output slbs_pkg::t_cmd    o_cmd
);
    import slbs_pkg::*;

    // ms / TICK_MS by reciprocal multiply, exact for every 16-bit ms
    localparam int unsigned ShiftW = 16 + $clog2(TICK_MS);
    localparam logic [16:0] RecipM = 17'((64'd1 << ShiftW) / TICK_MS + 64'd1);

    logic        r_valid;
    logic        r_is_req;
    logic [15:0] r_freq;
    logic [15:0] r_ms;
    logic [7:0]  r_count;

    logic [32:0] prod;
    logic [15:0] quot;
    logic [16:0] ticks_sum;
    logic [11:0] ticks;

    assign o_ready = !r_valid || i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_is_req <= i_is_req;
            r_freq   <= (i_freq == 16'd0) ? DEFAULT_FREQ : i_freq;
            r_ms     <= (i_ms == 16'd0) ? DEFAULT_MS : i_ms;
            r_count  <= (i_count == 8'd0) ? DEFAULT_COUNT : i_count;
        end
    end

    always_comb begin
        prod      = 33'(r_ms) * 33'(RecipM);
        quot      = 16'(prod >> ShiftW);
        ticks_sum = {1'b0, quot} + 17'd1;
        ticks     = (ticks_sum > 17'(TONE_TICK_MAX)) ? TONE_TICK_MAX : ticks_sum[11:0];
    end

    assign o_cmd_valid     = r_valid;
    assign o_cmd.is_req    = r_is_req;
    assign o_cmd.beep.freq  = r_freq;
    assign o_cmd.beep.ticks = ticks;
    assign o_cmd.beep.count = r_count;

endmodule

`default_nettype wire

// File: rtl/slbs_cmdq.sv
// short command queue between the front and back parts
// depends on slbs_pkg
`default_nettype none

module slbs_cmdq (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push_valid,
    output logic              o_push_ready,
    input  slbs_pkg::t_cmd    i_push_cmd,
    output logic              o_pop_valid,
    input  wire               i_pop_ready,
    output slbs_pkg::t_cmd    o_pop_cmd
);
    import slbs_pkg::*;

    localparam int unsigned PtrW = $clog2(CMDQ_DEPTH);
    localparam int unsigned CntW = $clog2(CMDQ_DEPTH + 1);

    t_cmd            r_mem [CMDQ_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != CntW'(CMDQ_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/slbs_back.sv
// back part: beep request fifo, tone sequencer, led rendering and result register
// depends on slbs_pkg
`default_nettype none

module slbs_back #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    input  wire  [2:0]            i_cfg_data,
    input  wire                   i_cmd_valid,
    output logic                  o_cmd_ready,
    input  slbs_pkg::t_cmd        i_cmd,
    output logic                  o_res_valid,
    input  wire                   i_res_ready,
    output logic [39:0]           o_res_data,
    output slbs_pkg::t_seq_status o_seq
);
    import slbs_pkg::*;

    localparam int unsigned IdxW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IdxW-1:0]  LastIdx   = IdxW'(QUEUE_DEPTH - 1);
    localparam logic [FillW-1:0] FullFill  = FillW'(QUEUE_DEPTH);
    localparam logic [4:0]       LastPhase = 5'(PHASE_STEPS - 1);

    t_beep            r_fifo [QUEUE_DEPTH];
    logic [IdxW-1:0]  r_head, n_head;
    logic [IdxW-1:0]  r_tail, n_tail;
    logic [FillW-1:0] r_fill, n_fill;
    logic [7:0]       r_beeps, n_beeps;
    logic [11:0]      r_tone, n_tone;
    logic [1:0]       r_gap, n_gap;
    logic [15:0]      r_freq, n_freq;
    logic [11:0]      r_ticks, n_ticks;
    logic             r_buzzer, n_buzzer;
    logic [4:0]       r_phase, n_phase;
    logic [2:0]       r_led_pattern;

    logic             r_out_valid;
    logic             r_out_status;
    logic             r_out_buzzer;
    logic [15:0]      r_out_freq;
    logic [6:0]       r_out_red;
    logic [5:0]       r_out_green;
    logic [6:0]       r_out_blue;

    logic             fire;
    logic             fifo_wr;
    logic             status;
    logic             pop;
    t_beep            head;
    logic [7:0]       beeps_eff;
    logic [11:0]      ticks_eff;
    logic [3:0]       ph_mod;
    logic             lit;
    logic [6:0]       red;
    logic [5:0]       green;
    logic [6:0]       blue;

    assign o_cmd_ready = !r_out_valid || i_res_ready;
    assign fire        = i_cmd_valid && o_cmd_ready;
    assign head        = r_fifo[r_head];

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_beeps   = r_beeps;
        n_tone    = r_tone;
        n_gap     = r_gap;
        n_freq    = r_freq;
        n_ticks   = r_ticks;
        n_buzzer  = r_buzzer;
        n_phase   = r_phase;
        fifo_wr   = 1'b0;
        status    = 1'b0;
        red       = '0;
        green     = '0;
        blue      = '0;
        pop       = (r_beeps == 8'd0) && (r_tone == 12'd0) && (r_gap == 2'd0)
                    && (r_fill != '0);
        beeps_eff = pop ? head.count : r_beeps;
        ticks_eff = pop ? head.ticks : r_ticks;
        ph_mod    = (r_phase >= 5'd10) ? 4'(r_phase - 5'd10) : r_phase[3:0];
        lit       = ph_mod < BLINK_ON_STEPS;

        if (fire && i_cmd.is_req) begin
            if (r_fill == FullFill) begin
                status = 1'b1;
            end else begin
                fifo_wr = 1'b1;
                n_fill  = r_fill + 1'b1;
                n_tail  = (r_tail == LastIdx) ? '0 : r_tail + 1'b1;
            end
        end else if (fire) begin
            if (pop) begin
                n_freq  = head.freq;
                n_ticks = head.ticks;
                n_beeps = head.count;
                n_fill  = r_fill - 1'b1;
                n_head  = (r_head == LastIdx) ? '0 : r_head + 1'b1;
            end
            if (beeps_eff != 8'd0 && r_tone == 12'd0 && r_gap == 2'd0) begin
                n_buzzer = 1'b1;
                n_tone   = ticks_eff;
            end else if (r_tone != 12'd0) begin
                n_tone = r_tone - 1'b1;
                if (r_tone == 12'd1) begin
                    n_buzzer = 1'b0;
                    n_gap    = GAP_TICKS;
                end
            end else if (r_gap != 2'd0) begin
                n_gap = r_gap - 1'b1;
                // a beep counts as done once its gap has run out
                if (r_gap == 2'd1 && r_beeps != 8'd0) begin
                    n_beeps = r_beeps - 1'b1;
                end
            end

            case (r_led_pattern)
                PAT_OFF: begin
                end
                PAT_BOOT_AMBER: begin
                    red   = AMBER_RED;
                    green = AMBER_GREEN;
                end
                PAT_OK_BREATHE: begin
                    green = BREATHE_BASE + 6'({2'b00, ph_mod} * BREATHE_STEP);
                end
                PAT_CONFIG_BLINK: begin
                    blue = lit ? CONFIG_BLUE : 7'd0;
                end
                PAT_UPDATE_RAMP: begin
                    red  = {r_phase, 2'b00};
                    blue = {r_phase, 2'b00};
                end
                PAT_FAULT_BLINK: begin
                    red = lit ? FAULT_RED : 7'd0;
                end
                default: begin
                end
            endcase

            n_phase = (r_phase == LastPhase) ? 5'd0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_beeps       <= '0;
            r_tone        <= '0;
            r_gap         <= '0;
            r_freq        <= '0;
            r_ticks       <= '0;
            r_buzzer      <= 1'b0;
            r_phase       <= '0;
            r_led_pattern <= PAT_BOOT_AMBER;
            r_out_valid   <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
            r_beeps  <= n_beeps;
            r_tone   <= n_tone;
            r_gap    <= n_gap;
            r_freq   <= n_freq;
            r_ticks  <= n_ticks;
            r_buzzer <= n_buzzer;
            r_phase  <= n_phase;
            if (i_cfg_valid) begin
                r_led_pattern <= i_cfg_data;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (fire) begin
            r_out_status <= status;
            r_out_buzzer <= n_buzzer;
            r_out_freq   <= n_freq;
            r_out_red    <= red;
            r_out_green  <= green;
            r_out_blue   <= blue;
        end
        if (fifo_wr) begin
            r_fifo[r_tail] <= i_cmd.beep;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_data  = {2'b00, r_out_blue, r_out_green, r_out_red, r_out_freq,
                          r_out_buzzer, r_out_status};

    assign o_seq.buzzer    = r_buzzer;
    assign o_seq.tone_on   = (r_tone != 12'd0);
    assign o_seq.gap_on    = (r_gap != 2'd0);
    assign o_seq.fifo_over = (r_fill > FullFill);

endmodule

`default_nettype wire

// File: rtl/status_led_and_beep_sequencer.sv
// Status LED and beep sequencer. Each input request is a tick (tuser 0) or a beep
// request (tuser 1); every request yields exactly one result. One request is taken
// per clock unless the output back-pressures; the result is registered through
// the input stage with the ms-to-ticks reciprocal multiply, the command queue and
// the sequencer/render stage. Beep requests queue in a QUEUE_DEPTH-entry fifo and
// are played on ticks; the led pattern register is
// written through the cfg channel, which is always ready.
// depends on slbs_pkg, slbs_front, slbs_cmdq, slbs_back
`default_nettype none

module status_led_and_beep_sequencer #(
    parameter int unsigned TICK_MS     = 50,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_data,   // led_pattern
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [39:0] i_s_tdata,    // tone_freq_req[15:0], tone_ms_req[31:16], beep_count_req[39:32]
    input  wire         i_s_tuser,    // operation
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata     // status[0], buzzer_active[1], tone_freq_hz[17:2],
                                      // red[24:18], green[30:25], blue[37:31], zero[39:38]
);
    import slbs_pkg::*;

    logic        w_f_valid;
    logic        w_f_ready;
    t_cmd        w_f_cmd;
    logic        w_q_valid;
    logic        w_q_ready;
    t_cmd        w_q_cmd;
    t_seq_status w_seq;

    assign o_cfg_ready = 1'b1;

    slbs_front #(
        .TICK_MS (TICK_MS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_is_req    (i_s_tuser),
        .i_freq      (i_s_tdata[15:0]),
        .i_ms        (i_s_tdata[31:16]),
        .i_count     (i_s_tdata[39:32]),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    slbs_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_cmd   (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    slbs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res_data  (o_m_tdata),
        .o_seq       (w_seq)
    );

    a_tone_gap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_seq.tone_on && w_seq.gap_on))
        else $error("tone and gap counters both running");

    a_buzzer_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seq.buzzer == w_seq.tone_on)
        else $error("buzzer level disagrees with tone counter");

    a_gap_after_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_seq.tone_on) |-> w_seq.gap_on)
        else $error("tone ended without a gap");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_seq.fifo_over)
        else $error("beep fifo fill beyond depth");

endmodule

`default_nettype wire
